// ===== sv/fca_pkg.sv =====
// shared constants and codes for the fat chain allocator
package fca_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int MAX_CHAIN   = 64;
    localparam int IDX_W       = 12;
    localparam int LIM_W       = 13;
    localparam int CNT_W       = 7;
    localparam int CHAIN_AW    = 6;

    // chain end marker
    localparam logic [31:0] END_MARK = 32'hFFFF_FFFF;

    // commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_ALLOC = 2'd2;
    localparam logic [1:0] CMD_WALK  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

endpackage

// ===== sv/fca_ram.sv =====
// generic single-port ram with registered read
module fca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fat_chain_allocator.sv =====
// fat chain allocator top level: command sequencer over the table ram
//
// One request is taken at a time; o_in_ready is high only while the block is idle.
// Allocate scans the table from entry 0, one ram read per cycle, until the requested
// number of free entries is found or the active range (fat_entries, capped at 4096)
// is exhausted, then links the chain block by block: it fetches the next block from
// the chain list, then writes the link into the table and reports the block. Walk
// reads each visited block, reports it and follows its link. All of this uses the
// single table ram port, and output stalls hold the sequencer. No clearing pass after
// reset: every table entry must be written before it is read or scanned.
module fat_chain_allocator
    import fca_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LIM_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [31:0]       i_entry_data,
    input  logic [CNT_W-1:0]  i_chain_blocks,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [IDX_W-1:0]  o_block_index,
    output logic [31:0]       o_read_value,
    output logic [1:0]        o_status,
    output logic              o_last
);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_RDONE  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_LRD    = 4'd4;
    localparam logic [3:0] S_LWR    = 4'd5;
    localparam logic [3:0] S_WRD    = 4'd6;
    localparam logic [3:0] S_WCHK   = 4'd7;
    localparam logic [3:0] S_WBAD   = 4'd8;

    localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CHAIN_LIM = CNT_W'(MAX_CHAIN);

    logic [3:0]       r_state, n_state;
    logic [LIM_W-1:0] r_fat_entries;
    logic [1:0]       r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_data;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [LIM_W-1:0] r_ptr, n_ptr;
    logic [CNT_W-1:0] r_found, n_found;
    logic [CNT_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic             r_chk, n_chk;
    logic [IDX_W-1:0] r_chk_addr, n_chk_addr;

    logic             r_out_valid, n_out_valid;
    logic [IDX_W-1:0] r_out_blk, n_out_blk;
    logic [31:0]      r_out_val, n_out_val;
    logic [1:0]       r_out_st, n_out_st;
    logic             r_out_last, n_out_last;

    logic             tbl_we, tbl_re;
    logic [IDX_W-1:0] tbl_addr;
    logic [31:0]      tbl_wdata, tbl_rdata;
    logic                chain_we, chain_re;
    logic [CHAIN_AW-1:0] chain_addr;
    logic [IDX_W-1:0]    chain_wdata, chain_rdata;

    logic             in_acc, slot_free, hit, more, fin, next_bad, emit;
    logic [LIM_W-1:0] lim;
    logic [CNT_W-1:0] found_n, i_p1;
    logic [IDX_W-1:0] e_blk;
    logic [31:0]      e_val, nxt;
    logic [1:0]       e_st;
    logic             e_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign lim        = (r_fat_entries > DEPTH_LIM) ? DEPTH_LIM : r_fat_entries;
    assign hit        = r_chk && (tbl_rdata == 32'd0);
    assign found_n    = r_found + {{(CNT_W-1){1'b0}}, hit};
    assign i_p1       = r_i + CNT_W'(1);
    assign more       = i_p1 < r_cnt;
    assign fin        = (i_p1 == r_cnt) || (tbl_rdata == END_MARK);
    assign next_bad   = (tbl_rdata[31:LIM_W] != '0) || (tbl_rdata[LIM_W-1:0] >= lim);

    // table and chain list storage
    fca_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_re    (tbl_re),
        .i_addr  (tbl_addr),
        .i_wdata (tbl_wdata),
        .o_rdata (tbl_rdata)
    );

    fca_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CHAIN)) u_chain (
        .i_clk   (i_clk),
        .i_we    (chain_we),
        .i_re    (chain_re),
        .i_addr  (chain_addr),
        .i_wdata (chain_wdata),
        .o_rdata (chain_rdata)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ptr      = r_ptr;
        n_found    = r_found;
        n_i        = r_i;
        n_cur      = r_cur;
        n_chk      = r_chk;
        n_chk_addr = r_chk_addr;
        tbl_we      = 1'b0;
        tbl_re      = 1'b0;
        tbl_addr    = r_idx;
        tbl_wdata   = r_data;
        chain_we    = 1'b0;
        chain_re    = 1'b0;
        chain_addr  = r_found[CHAIN_AW-1:0];
        chain_wdata = r_chk_addr;
        nxt    = END_MARK;
        emit   = 1'b0;
        e_blk  = '0;
        e_val  = '0;
        e_st   = ST_OK;
        e_last = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                if (r_cmd == CMD_WRITE || r_cmd == CMD_READ) begin
                    if ({1'b0, r_idx} >= lim) begin
                        if (slot_free) begin
                            emit    = 1'b1;
                            e_st    = ST_RANGE;
                            n_state = S_IDLE;
                        end
                    end else if (r_cmd == CMD_READ) begin
                        tbl_re  = 1'b1;
                        n_state = S_RDONE;
                    end else if (slot_free) begin
                        tbl_we  = 1'b1;
                        emit    = 1'b1;
                        e_blk   = r_idx;
                        n_state = S_IDLE;
                    end
                end else if (r_cnt == '0) begin
                    if (slot_free) begin
                        emit    = 1'b1;
                        e_st    = ST_NONE;
                        n_state = S_IDLE;
                    end
                end else if (r_cmd == CMD_ALLOC) begin
                    if (r_cnt > CHAIN_LIM) begin
                        if (slot_free) begin
                            emit    = 1'b1;
                            e_st    = ST_NO_SPACE;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_ptr   = '0;
                        n_found = '0;
                        n_chk   = 1'b0;
                        n_state = S_SCAN;
                    end
                end else begin
                    if ({1'b0, r_idx} >= lim) begin
                        if (slot_free) begin
                            emit    = 1'b1;
                            e_st    = ST_RANGE;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_cur   = r_idx;
                        n_i     = '0;
                        n_cnt   = (r_cnt > CHAIN_LIM) ? CHAIN_LIM : r_cnt;
                        n_state = S_WRD;
                    end
                end
            end

            S_RDONE: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_blk   = r_idx;
                    e_val   = tbl_rdata;
                    n_state = S_IDLE;
                end
            end

            // free entry scan, one read issued and one checked per cycle
            S_SCAN: begin
                if (hit) begin
                    chain_we = 1'b1;
                    if (r_found == '0) begin
                        n_cur = r_chk_addr;
                    end
                end
                n_found = found_n;
                if (found_n == r_cnt) begin
                    n_chk   = 1'b0;
                    n_i     = '0;
                    n_state = S_LRD;
                end else if (r_ptr < lim) begin
                    tbl_re     = 1'b1;
                    tbl_addr   = r_ptr[IDX_W-1:0];
                    n_chk      = 1'b1;
                    n_chk_addr = r_ptr[IDX_W-1:0];
                    n_ptr      = r_ptr + LIM_W'(1);
                end else if (r_chk) begin
                    n_chk = 1'b0;
                end else if (slot_free) begin
                    emit    = 1'b1;
                    e_st    = ST_NO_SPACE;
                    n_state = S_IDLE;
                end
            end

            // fetch the next block of the chain
            S_LRD: begin
                if (more) begin
                    chain_re   = 1'b1;
                    chain_addr = i_p1[CHAIN_AW-1:0];
                end
                n_state = S_LWR;
            end

            // link the current block and report it
            S_LWR: begin
                nxt = more ? {{(32-IDX_W){1'b0}}, chain_rdata} : END_MARK;
                if (slot_free) begin
                    tbl_we    = 1'b1;
                    tbl_addr  = r_cur;
                    tbl_wdata = nxt;
                    emit      = 1'b1;
                    e_blk     = r_cur;
                    e_last    = !more;
                    if (more) begin
                        n_cur   = chain_rdata;
                        n_i     = i_p1;
                        n_state = S_LRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_WRD: begin
                tbl_re   = 1'b1;
                tbl_addr = r_cur;
                n_state  = S_WCHK;
            end

            // report visited block and follow its link
            S_WCHK: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_blk  = r_cur;
                    e_last = fin;
                    if (fin) begin
                        n_state = S_IDLE;
                    end else if (next_bad) begin
                        n_state = S_WBAD;
                    end else begin
                        n_cur   = tbl_rdata[IDX_W-1:0];
                        n_i     = i_p1;
                        n_state = S_WRD;
                    end
                end
            end

            S_WBAD: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_st    = ST_RANGE;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_blk   = r_out_blk;
        n_out_val   = r_out_val;
        n_out_st    = r_out_st;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_blk   = e_blk;
            n_out_val   = e_val;
            n_out_st    = e_st;
            n_out_last  = e_last;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_chk         <= 1'b0;
            r_fat_entries <= LIM_W'(4096);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chk       <= n_chk;
            if (i_cfg_we) begin
                r_fat_entries <= i_cfg_wdata;
            end
        end
    end

    // request and working registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_idx  <= i_entry_index;
            r_data <= i_entry_data;
            r_cnt  <= i_chain_blocks;
        end else begin
            r_cnt <= n_cnt;
        end
        r_ptr      <= n_ptr;
        r_found    <= n_found;
        r_i        <= n_i;
        r_cur      <= n_cur;
        r_chk_addr <= n_chk_addr;
        r_out_blk  <= n_out_blk;
        r_out_val  <= n_out_val;
        r_out_st   <= n_out_st;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_block_index = r_out_blk;
    assign o_read_value  = r_out_val;
    assign o_status      = r_out_st;
    assign o_last        = r_out_last;

    // chain list is only filled during the scan
    a_chain_we_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_we |-> r_state == S_SCAN)
        else $error("chain list written outside scan");

    // table writes only when the matching result can be loaded
    a_tbl_we_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |-> slot_free && (r_state == S_DECODE || r_state == S_LWR))
        else $error("table written without result slot");

    // the scan never collects more blocks than requested
    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_found < r_cnt)
        else $error("scan found count overran request");

    // one request at a time
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request accepted while busy");

endmodule

// ===== verif/fat_chain_allocator_tb.sv =====
// self-checking testbench for the fat chain allocator: directed and random requests
`timescale 1ns / 1ps

module fat_chain_allocator_tb;
    import fca_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] blk;
        logic [31:0]      value;
        logic [1:0]       status;
        logic             last;
    } fat_result_t;

    // table model, expected results and the checker
    class chain_scoreboard;
        logic [31:0]      fat_table [TABLE_DEPTH];
        bit               written   [TABLE_DEPTH];
        logic [IDX_W-1:0] chain_list [MAX_CHAIN];
        int unsigned      chain_len;
        int unsigned      entries_cfg;
        int               mismatches;
        fat_result_t      expected_q [$];

        function new();
            foreach (fat_table[i]) begin
                fat_table[i] = '0;
                written[i]   = 1'b0;
            end
            chain_len   = 0;
            entries_cfg = TABLE_DEPTH;
            mismatches  = 0;
        endfunction

        function int unsigned active_limit();
            return (entries_cfg > TABLE_DEPTH) ? TABLE_DEPTH : entries_cfg;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_result(int unsigned blk, logic [31:0] value, logic [1:0] status,
                                  bit last);
            fat_result_t r;
            r.blk    = IDX_W'(blk);
            r.value  = value;
            r.status = status;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // first entry this request would read before it was ever written, or -1
        function int first_unwritten(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                                     logic [CNT_W-1:0] cnt);
            int unsigned lim;
            int unsigned found;
            int unsigned steps;
            int unsigned cur;
            logic [31:0] nxt;
            lim = active_limit();
            if (cmd == CMD_WRITE)
                return -1;
            if (cmd == CMD_READ)
                return (idx < lim && !written[idx]) ? int'(idx) : -1;
            if (cnt == 0)
                return -1;
            if (cmd == CMD_ALLOC) begin
                if (cnt > MAX_CHAIN)
                    return -1;
                found = 0;
                for (int i = 0; i < lim && found < cnt; i++) begin
                    if (!written[i])
                        return i;
                    if (fat_table[i] == 0)
                        found++;
                end
                return -1;
            end
            if (idx >= lim)
                return -1;
            steps = (cnt > MAX_CHAIN) ? MAX_CHAIN : cnt;
            cur = idx;
            for (int i = 0; i < steps; i++) begin
                if (!written[cur])
                    return cur;
                nxt = fat_table[cur];
                if (i + 1 == steps || nxt == END_MARK || nxt >= lim)
                    return -1;
                cur = nxt;
            end
            return -1;
        endfunction

        // predict the results of one accepted request and update the table
        function void note_request(logic [1:0] cmd, logic [IDX_W-1:0] idx,
                                   logic [31:0] data, logic [CNT_W-1:0] cnt);
            int unsigned lim;
            int unsigned steps;
            int unsigned cur;
            logic [31:0] nxt;
            bit          fin;
            int          picked [$];
            lim = active_limit();
            if (cmd == CMD_WRITE || cmd == CMD_READ) begin
                if (idx >= lim) begin
                    push_result(0, '0, ST_RANGE, 1'b1);
                end else if (cmd == CMD_WRITE) begin
                    fat_table[idx] = data;
                    written[idx]   = 1'b1;
                    push_result(idx, '0, ST_OK, 1'b1);
                end else begin
                    push_result(idx, fat_table[idx], ST_OK, 1'b1);
                end
            end else if (cnt == 0) begin
                push_result(0, '0, ST_NONE, 1'b1);
            end else if (cmd == CMD_ALLOC) begin
                if (cnt <= MAX_CHAIN) begin
                    for (int i = 0; i < lim && picked.size() < cnt; i++)
                        if (fat_table[i] == 0)
                            picked.push_back(i);
                end
                if (cnt > MAX_CHAIN || picked.size() < cnt) begin
                    push_result(0, '0, ST_NO_SPACE, 1'b1);
                end else begin
                    // link the picked entries in ascending order
                    chain_len = cnt;
                    foreach (picked[i]) begin
                        chain_list[i] = IDX_W'(picked[i]);
                        fat_table[picked[i]] = (i + 1 < cnt) ? picked[i + 1] : END_MARK;
                        push_result(picked[i], '0, ST_OK, i + 1 == cnt);
                    end
                end
            end else if (idx >= lim) begin
                push_result(0, '0, ST_RANGE, 1'b1);
            end else begin
                // follow links until the count, the end marker or a bad link
                steps = (cnt > MAX_CHAIN) ? MAX_CHAIN : cnt;
                cur = idx;
                for (int i = 0; i < steps; i++) begin
                    nxt = fat_table[cur];
                    fin = (i + 1 == steps) || (nxt == END_MARK);
                    push_result(cur, '0, ST_OK, fin);
                    if (fin)
                        break;
                    if (nxt >= lim) begin
                        push_result(0, '0, ST_RANGE, 1'b1);
                        break;
                    end
                    cur = nxt;
                end
            end
        endfunction

        function void check_result(fat_result_t got);
            fat_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: unexpected result block %0d value %h status %0d last %0b",
                             $time, got.blk, got.value, got.status, got.last);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatches++;
                // keep the log readable when something is badly off
                if (mismatches <= 100)
                    $display({"%0t: mismatch expected block %0d value %h status %0d last %0b,",
                              " got block %0d value %h status %0d last %0b"},
                             $time, want.blk, want.value, want.status, want.last,
                             got.blk, got.value, got.status, got.last);
            end
        endfunction
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_we       = 1'b0;
    logic [LIM_W-1:0]  i_cfg_wdata    = '0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_cmd          = CMD_WRITE;
    logic [IDX_W-1:0]  i_entry_index  = '0;
    logic [31:0]       i_entry_data   = '0;
    logic [CNT_W-1:0]  i_chain_blocks = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic [IDX_W-1:0]  o_block_index;
    logic [31:0]       o_read_value;
    logic [1:0]        o_status;
    logic              o_last;

    int send_idle_pct = 26;
    int recv_idle_pct = 60;
    chain_scoreboard fat_sb;

    fat_chain_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_entry_index  (i_entry_index),
        .i_entry_data   (i_entry_data),
        .i_chain_blocks (i_chain_blocks),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_block_index  (o_block_index),
        .o_read_value   (o_read_value),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check accepted results, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            fat_sb.check_result({o_block_index, o_read_value, o_status, o_last});
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // present one request and hold it until accepted
    task automatic send_request(input logic [1:0] cmd, input logic [IDX_W-1:0] idx,
                                input logic [31:0] data, input logic [CNT_W-1:0] cnt);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= cmd;
        i_entry_index  <= idx;
        i_entry_data   <= data;
        i_chain_blocks <= cnt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        fat_sb.note_request(cmd, idx, data, cnt);
    endtask

    // drain all results, then change the table size while idle
    task automatic set_entries(input logic [LIM_W-1:0] value);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (fat_sb.pending() != 0 || !o_in_ready) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fat_sb.entries_cfg = value;
    endtask

    // random requests; walks often start at the head of the last allocated chain
    task automatic run_random(input int n);
        logic [1:0]       cmd;
        logic [IDX_W-1:0] idx;
        logic [31:0]      data;
        logic [CNT_W-1:0] cnt;
        int unsigned      lim;
        int unsigned      near_max;
        int               roll;
        int               fix;
        for (int k = 0; k < n; k++) begin
            lim      = fat_sb.active_limit();
            near_max = (lim + 3 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : lim + 3;
            idx = ($urandom_range(3) == 0) ? IDX_W'($urandom_range(TABLE_DEPTH - 1))
                                           : IDX_W'($urandom_range(near_max));
            roll = $urandom_range(99);
            if (roll < 45)
                data = '0;
            else if (roll < 70)
                data = $urandom_range(near_max);
            else if (roll < 80)
                data = END_MARK;
            else
                data = $urandom;
            roll = $urandom_range(99);
            if (roll < 8)
                cnt = '0;
            else if (roll < 16)
                cnt = CNT_W'($urandom_range(127, 65));
            else if (roll < 22)
                cnt = CNT_W'(MAX_CHAIN);
            else
                cnt = CNT_W'($urandom_range(8, 1));

            roll = $urandom_range(99);
            if (roll < 28) begin
                cmd = CMD_WRITE;
                // often grow the initialized prefix of the table
                fix = fat_sb.first_unwritten(CMD_ALLOC, '0, CNT_W'(MAX_CHAIN));
                if (fix >= 0 && $urandom_range(99) < 40)
                    idx = IDX_W'(fix);
            end else if (roll < 45) begin
                cmd = CMD_READ;
            end else if (roll < 72) begin
                cmd = CMD_ALLOC;
            end else begin
                cmd = CMD_WALK;
                if (fat_sb.chain_len > 0 && $urandom_range(99) < 55) begin
                    idx = fat_sb.chain_list[0];
                    cnt = CNT_W'(fat_sb.chain_len + $urandom_range(2));
                end
            end

            // never touch an entry that was not written: initialize it instead
            fix = fat_sb.first_unwritten(cmd, idx, cnt);
            if (fix >= 0) begin
                cmd  = CMD_WRITE;
                idx  = IDX_W'(fix);
                data = '0;
            end
            send_request(cmd, idx, data, cnt);
        end
    endtask

    // main sequence
    initial begin
        fat_sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: four-entry table
        set_entries(4);
        send_request(CMD_WRITE, 0, 32'h0, 0);
        send_request(CMD_WRITE, 1, 32'h0, 0);
        send_request(CMD_WRITE, 2, 32'h0, 0);
        send_request(CMD_WRITE, 3, 32'h0, 0);
        send_request(CMD_ALLOC, 0, 32'h0, 3);
        send_request(CMD_WALK, 0, 32'h0, 10);
        // not enough free entries, zero count, count above the chain limit
        send_request(CMD_ALLOC, 0, 32'h0, 2);
        send_request(CMD_ALLOC, 0, 32'h0, 0);
        send_request(CMD_ALLOC, 0, 32'h0, 127);
        send_request(CMD_ALLOC, 0, 32'h0, 64);
        send_request(CMD_WALK, 0, 32'h0, 0);
        // start and indexes out of range
        send_request(CMD_WALK, 4, 32'h0, 1);
        send_request(CMD_READ, 0, 32'h0, 0);
        send_request(CMD_WRITE, 4095, 32'hFFFF_FFFF, 0);
        send_request(CMD_READ, 4095, 32'h0, 0);
        // link pointing out of range
        send_request(CMD_WRITE, 1, 32'd100, 0);
        send_request(CMD_WALK, 0, 32'h0, 5);
        // self loop walked past the chain limit
        send_request(CMD_WRITE, 3, 32'd3, 0);
        send_request(CMD_WALK, 3, 32'h0, 127);
        send_request(CMD_READ, 2, 32'h0, 0);
        send_request(CMD_WRITE, 0, 32'h0, 0);
        send_request(CMD_ALLOC, 0, 32'h0, 1);

        set_entries(96);
        run_random(35);

        // sender idles more than the receiver
        send_idle_pct = 60;
        recv_idle_pct = 26;
        set_entries(4096);
        send_request(CMD_WRITE, 4095, $urandom, 0);
        send_request(CMD_READ, 4095, 32'h0, 0);
        run_random(35);
        set_entries(1);
        run_random(10);

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_entries(60);
        run_random(35);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (fat_sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fat_sb.mismatches == 0)
            $display("fat_chain_allocator test passed");
        else
            $display("fat_chain_allocator test failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("fat_chain_allocator test failed");
        $finish;
    end

endmodule
